// ===== rtl/core/utf8v_pkg.sv =====
// utf8v_pkg: types, constants and the sequence check for the utf-8 stream validator
// no dependencies; used by utf8v_step and utf8_stream_validator
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] ONE_MAX     = 21'h00007F;
    localparam logic [CP_W-1:0] TWO_MAX     = 21'h0007FF;
    localparam logic [CP_W-1:0] THREE_MAX   = 21'h00FFFF;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    localparam logic [1:0] CONT_TAG = 2'b10;

    // decoder state carried between bytes
    typedef struct packed {
        logic [1:0]       pending;
        logic [LEN_W-1:0] seq_len;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] max_len;
        logic             err;
        logic             term;
    } dec_state_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] longest;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '0;

    // range, surrogate and overlong check of a completed sequence
    function automatic logic seq_bad(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len);
        logic bad;
        bad = 1'b0;
        if (cp > CP_MAX) bad = 1'b1;
        if (cp >= SURR_LO && cp <= SURR_HI) bad = 1'b1;
        if (cp <= ONE_MAX && len != LEN_ONE) bad = 1'b1;
        if (cp > ONE_MAX && cp <= TWO_MAX && len != LEN_TWO) bad = 1'b1;
        if (cp > TWO_MAX && cp <= THREE_MAX && len != LEN_THREE) bad = 1'b1;
        if (cp > THREE_MAX && len != LEN_FOUR) bad = 1'b1;
        return bad;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8v_step.sv =====
// utf8v_step: next-state and result logic for one byte of the string
// depends on utf8v_pkg
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step (
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_string,
    input  wire utf8v_pkg::dec_state_t cur,
    output utf8v_pkg::dec_state_t      nxt,
    output utf8v_pkg::dec_result_t     res
);

    utf8v_pkg::dec_state_t upd;
    logic                  fin;
    logic [utf8v_pkg::CP_W-1:0]  fin_cp;
    logic [utf8v_pkg::LEN_W-1:0] fin_len;

    always_comb
    begin
        upd     = cur;
        fin     = 1'b0;
        fin_cp  = cur.cp;
        fin_len = cur.seq_len;
        if (!cur.err && !cur.term)
        begin
            if (cur.pending == 2'd0)
            begin
                case (data_byte) inside
                    8'h00:
                    begin
                        upd.term = 1'b1;
                    end
                    [8'h01:8'h7F]:
                    begin
                        upd.cp      = {13'd0, data_byte};
                        upd.seq_len = utf8v_pkg::LEN_ONE;
                        fin         = 1'b1;
                        fin_cp      = {13'd0, data_byte};
                        fin_len     = utf8v_pkg::LEN_ONE;
                    end
                    [8'hC0:8'hDF]:
                    begin
                        upd.cp      = {16'd0, data_byte[4:0]};
                        upd.seq_len = utf8v_pkg::LEN_TWO;
                        upd.pending = 2'd1;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        upd.cp      = {17'd0, data_byte[3:0]};
                        upd.seq_len = utf8v_pkg::LEN_THREE;
                        upd.pending = 2'd2;
                    end
                    [8'hF0:8'hF7]:
                    begin
                        upd.cp      = {18'd0, data_byte[2:0]};
                        upd.seq_len = utf8v_pkg::LEN_FOUR;
                        upd.pending = 2'd3;
                    end
                    default:
                    begin
                        upd.err = 1'b1;
                    end
                endcase
            end
            else if (data_byte[7:6] != utf8v_pkg::CONT_TAG)
            begin
                upd.err = 1'b1;
            end
            else
            begin
                upd.cp      = {cur.cp[utf8v_pkg::CP_W-7:0], data_byte[5:0]};
                upd.pending = cur.pending - 2'd1;
                fin         = (cur.pending == 2'd1);
                fin_cp      = {cur.cp[utf8v_pkg::CP_W-7:0], data_byte[5:0]};
            end
        end

        if (fin)
        begin
            if (utf8v_pkg::seq_bad(fin_cp, fin_len))
                upd.err = 1'b1;
            else if (fin_len > cur.max_len)
                upd.max_len = fin_len;
        end
    end

    always_comb
    begin
        res.valid   = !upd.err && (upd.pending == 2'd0);
        res.longest = res.valid ? upd.max_len : '0;
        nxt         = end_of_string ? utf8v_pkg::STATE_CLEAR : upd;
    end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_validator.sv =====
// utf8_stream_validator: checks a byte stream for well-formed utf-8, one result per string
// depends on utf8v_pkg and utf8v_step
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   in       | in_valid / in_ready | data_byte[7:0], end_of_string
//   out      | out_valid/out_ready | is_valid, longest_sequence[2:0]
//
// one byte per cycle while in_ready is high; a byte waits in the input register,
// and the edge that moves it into the decode state also loads the output register
// for a final byte, so out_valid rises from the output register, behind the input
// register; bytes that carry no end of string pass on even while a result waits;
// a final byte holds in the input register until the output register is free
// rst_n clears the decode state and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_string,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            is_valid,
    output logic [2:0]      longest_sequence
);

    logic       stg_vld_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_eos_reg;

    utf8v_pkg::dec_state_t  st_reg;
    utf8v_pkg::dec_state_t  st_next;
    utf8v_pkg::dec_result_t step_res;

    logic                        res_vld_reg;
    logic                        res_ok_reg;
    logic [utf8v_pkg::LEN_W-1:0] res_len_reg;

    logic advance;
    logic stg_fire;

    assign advance  = !stg_eos_reg || !res_vld_reg || out_ready;
    assign stg_fire = stg_vld_reg && advance;
    assign in_ready = !stg_vld_reg || advance;

    utf8v_step u_step (
        .data_byte     (stg_byte_reg),
        .end_of_string (stg_eos_reg),
        .cur           (st_reg),
        .nxt           (st_next),
        .res           (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_vld_reg <= 1'b0;
        else if (in_ready)
            stg_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_byte_reg <= data_byte;
            stg_eos_reg  <= end_of_string;
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= utf8v_pkg::STATE_CLEAR;
        else if (stg_fire)
            st_reg <= st_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (stg_fire && stg_eos_reg)
            res_vld_reg <= 1'b1;
        else if (out_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire && stg_eos_reg)
        begin
            res_ok_reg  <= step_res.valid;
            res_len_reg <= step_res.longest;
        end
    end

    assign out_valid        = res_vld_reg;
    assign is_valid         = res_ok_reg;
    assign longest_sequence = res_len_reg;

    // a rejected string never reports a length
    a_invalid_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_valid |-> longest_sequence == 3'd0)
        else $error("invalid string reported a nonzero length");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> longest_sequence <= utf8v_pkg::LEN_FOUR)
        else $error("longest sequence out of range");

    a_pending_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pending != 2'd0 |-> st_reg.seq_len > {1'b0, st_reg.pending})
        else $error("pending count exceeds sequence length");

    a_err_term_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.err && st_reg.term))
        else $error("error and terminator both set");

    // the final byte leaves the decoder cleared for the next string
    a_clear_after_eos: assert property (@(posedge clk) disable iff (!rst_n)
        stg_fire && stg_eos_reg |=> st_reg == utf8v_pkg::STATE_CLEAR && out_valid)
        else $error("state not cleared after end of string");

endmodule

`default_nettype wire
